>>> src/solp_pkg.sv
package solp_pkg;

   localparam int MAX_SEGMENTS_DEFAULT = 1024;

   localparam int MODE_W      = 2;
   localparam int VALUE_W     = 42;
   localparam int TOTAL_W     = 43;
   localparam int LEN_W       = 32;
   localparam int SEG_INDEX_W = 11;

   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [LEN_W-1:0]   LEN_MAX   = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CHECK,
      ST_SEARCH,
      ST_RESULT
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type         op;
      logic [TOTAL_W-1:0] a;
      logic [TOTAL_W-1:0] b;
   } alu_req_type;

endpackage

>>> src/solp_alu.sv
// Shared add / subtract unit; the top bit is carry out or borrow.
module solp_alu import solp_pkg::*; (
   input  alu_req_type        alu_req,
   output logic [TOTAL_W:0]   alu_result
);

   logic [TOTAL_W:0] a_ext;
   logic [TOTAL_W:0] b_ext;

   assign a_ext = {1'b0, alu_req.a};
   assign b_ext = {1'b0, alu_req.b};

   always_comb begin
      unique case (alu_req.op)
         ALU_ADD: alu_result = a_ext + b_ext;
         ALU_SUB: alu_result = a_ext - b_ext;
      endcase
   end

endmodule

>>> src/solp_table.sv
// Prefix-sum store: one write port, one read port with registered data.
module solp_table import solp_pkg::*; #(
   parameter  int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT,
   localparam int ADDR_W       = $clog2(MAX_SEGMENTS)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [TOTAL_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [TOTAL_W-1:0] rd_data
);

   logic [TOTAL_W-1:0] mem [MAX_SEGMENTS];
   logic [TOTAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/segment_offset_lookup.sv
// Segment offset lookup. Load words (mode 0) append a segment length, clamped
// to 32 bits, to a prefix-sum table of MAX_SEGMENTS entries; the running total
// saturates at 2^43-1 and loads into a full table are dropped. A clear word
// (mode 2) empties the table in its accept cycle; mode 3 is dropped. A query
// word (mode 1) returns one response word with the 1-based segment index and
// the 1-based offset inside it, or found=0 with zero fields for position 0,
// an empty table or a position beyond the total. The block takes one word at
// a time: a load keeps req_ready low after acceptance, a clear does not, and
// a query keeps it low through its check, its binary-search steps over the
// n loaded segments (at most clog2(n+1), 11 at 1024 segments) and its result
// state, which waits for a free output slot. Each search step is one read of
// the table's single read port and one pass through the shared 44-bit adder.
// A finished response sits in an output register, so the next word is taken
// while it waits for rsp_ready. No clearing pass is needed after reset.
module segment_offset_lookup import solp_pkg::*; #(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [VALUE_W-1:0]     req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SEG_INDEX_W-1:0] rsp_segment_index,
   output logic [LEN_W-1:0]       rsp_offset,
   output logic                   rsp_found
);

   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int ADDR_W = $clog2(MAX_SEGMENTS);

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   loaded_ff, loaded_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // working registers of the current word
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [TOTAL_W-1:0] before_ff, before_in;
   logic               found_ff, found_in;

   // response register
   logic [SEG_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [LEN_W-1:0]       rsp_offset_ff, rsp_offset_in;
   logic                   rsp_found_ff, rsp_found_in;

   // shared adder and table
   alu_req_type        alu_req;
   logic [TOTAL_W:0]   alu_result;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [TOTAL_W-1:0] wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [TOTAL_W-1:0] rd_data;

   logic [LEN_W-1:0]   len_clamped;
   logic               table_full;
   logic               rsp_slot_free;
   logic               entry_ge;
   logic [CNT_W-1:0]   lo_step, hi_step;
   logic [CNT_W:0]     mid_sum;
   logic [CNT_W-1:0]   mid_step;

   solp_alu u_alu (
      .alu_req    (alu_req),
      .alu_result (alu_result)
   );

   solp_table #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // clamp long lengths to the 32-bit maximum
   assign len_clamped   = (value_ff[VALUE_W-1:LEN_W] != '0) ? LEN_MAX : value_ff[LEN_W-1:0];
   assign table_full    = (loaded_ff == CNT_W'(MAX_SEGMENTS));
   assign rsp_slot_free = !rsp_valid_ff || rsp_ready;

   // in a search step the adder forms entry - position; no borrow means entry >= position
   assign entry_ge = !alu_result[TOTAL_W];

   // next search bounds and midpoint; the midpoint addresses the table directly
   always_comb begin
      lo_step = lo_ff;
      hi_step = hi_ff;
      if (state_ff == ST_CHECK) begin
         lo_step = '0;
         hi_step = loaded_ff;
      end else if (state_ff == ST_SEARCH) begin
         if (entry_ge) begin
            hi_step = mid_ff;
         end else begin
            lo_step = mid_ff + 1'b1;
         end
      end
   end

   assign mid_sum  = {1'b0, lo_step} + {1'b0, hi_step};
   assign mid_step = mid_sum[CNT_W:1];
   assign rd_addr  = mid_step[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loaded_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      before_ff     <= before_in;
      found_ff      <= found_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_found_ff  <= rsp_found_in;
   end

   always_comb begin
      state_in      = state_ff;
      loaded_in     = loaded_ff;
      total_in      = total_ff;
      value_in      = value_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      before_in     = before_ff;
      found_in      = found_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_ready     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = loaded_ff[ADDR_W-1:0];
      wr_data       = total_ff;
      alu_req.op    = ALU_ADD;
      alu_req.a     = total_ff;
      alu_req.b     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               value_in = req_value;
               unique case (req_mode)
                  MODE_LOAD:  state_in = ST_LOAD;
                  MODE_QUERY: state_in = ST_CHECK;
                  MODE_CLEAR: begin
                     loaded_in = '0;
                     total_in  = '0;
                  end
                  default: ;
               endcase
            end
         end

         ST_LOAD: begin
            // saturate the running total, store it and advance the fill count
            alu_req.op = ALU_ADD;
            alu_req.a  = total_ff;
            alu_req.b  = {{(TOTAL_W-LEN_W){1'b0}}, len_clamped};
            if (!table_full) begin
               total_in  = alu_result[TOTAL_W] ? TOTAL_MAX : alu_result[TOTAL_W-1:0];
               wr_en     = 1'b1;
               wr_data   = total_in;
               loaded_in = loaded_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end

         ST_CHECK: begin
            // total - position: a borrow means the position lies beyond the total
            alu_req.op = ALU_SUB;
            alu_req.a  = total_ff;
            alu_req.b  = {1'b0, value_ff};
            lo_in      = lo_step;
            hi_in      = hi_step;
            mid_in     = mid_step;
            before_in  = '0;
            if ((value_ff == '0) || (loaded_ff == '0) || alu_result[TOTAL_W]) begin
               found_in = 1'b0;
               state_in = ST_RESULT;
            end else begin
               state_in = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            // an entry below the position becomes the end of the previous segment
            alu_req.op = ALU_SUB;
            alu_req.a  = rd_data;
            alu_req.b  = {1'b0, value_ff};
            lo_in      = lo_step;
            hi_in      = hi_step;
            mid_in     = mid_step;
            if (!entry_ge) begin
               before_in = rd_data;
            end
            if (lo_step >= hi_step) begin
               found_in = 1'b1;
               state_in = ST_RESULT;
            end
         end

         ST_RESULT: begin
            // offset inside the segment: position - previous prefix sum
            alu_req.op = ALU_SUB;
            alu_req.a  = {1'b0, value_ff};
            alu_req.b  = before_ff;
            if (rsp_slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_index_in  = found_ff ? SEG_INDEX_W'({1'b0, lo_ff} + 1'b1) : '0;
               rsp_offset_in = found_ff ? alu_result[LEN_W-1:0] : '0;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_segment_index = rsp_index_ff;
   assign rsp_offset        = rsp_offset_ff;
   assign rsp_found         = rsp_found_ff;

endmodule

>>> src/solp_checker.sv
module solp_checker import solp_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic [MODE_W-1:0]      req_mode,
   input logic [VALUE_W-1:0]     req_value,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [SEG_INDEX_W-1:0] rsp_segment_index,
   input logic [LEN_W-1:0]       rsp_offset,
   input logic                   rsp_found
);

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_segment_index)
         && $stable(rsp_offset) && $stable(rsp_found))
      else $error("response word changed while stalled");

   // a miss carries zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_segment_index == '0) && (rsp_offset == '0))
      else $error("miss with non-zero fields");

   // a hit lands at a 1-based offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (rsp_offset != '0))
      else $error("hit with zero offset");

   // loads and queries occupy the block after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && ((req_mode == MODE_LOAD) || (req_mode == MODE_QUERY))
         |=> !req_ready)
      else $error("ready after accepting a load or query");

   // a response appears only at the end of a query's work
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised without query work");

endmodule

bind segment_offset_lookup solp_checker u_solp_checker (.*);
